/* rtl/rcfd_pkg.sv */
// Package for the remote-control frame decoder.
// Holds the word types, status codes, register indexes and reset values.
// Used by rcfd_unpack and rc_frame_decoder_unit; depends on nothing.
package rcfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int STICK_W     = 11;
    localparam int NUM_STICKS  = 4;
    localparam int STORE_DEPTH = 16;
    localparam int STORE_IDX_W = 4;
    localparam int CNT_W       = 5;
    localparam int LIMIT_W     = 7;
    localparam int THRESH_W    = 4;
    localparam int OFFSET_W    = 8;
    localparam int DIFF_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int MOUSE_W     = 48;
    localparam int KEY_W       = 16;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_RANGE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_AFTER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE_AFTER = 3'd5;

    // Reset values
    localparam logic [STICK_W-1:0]  RST_STICK_MIN       = 11'd344;
    localparam logic [STICK_W-1:0]  RST_STICK_MAX       = 11'd1704;
    localparam logic [STICK_W-1:0]  RST_STICK_CENTER    = 11'd1024;
    localparam logic [LIMIT_W-1:0]  RST_OFFSET_LIMIT    = 7'd30;
    localparam logic [THRESH_W-1:0] RST_HISTORY_AFTER   = 4'd5;
    localparam logic [THRESH_W-1:0] RST_CALIBRATE_AFTER = 4'd10;
    localparam logic [3:0]          RST_SWITCHES        = 4'hF;
    localparam logic [CNT_W-1:0]    CNT_MAX             = 5'd31;
    localparam logic [THRESH_W-1:0] ACC_MAX             = 4'd15;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              burst_end;
    } rcfd_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [STICK_W-1:0] stick0;
        logic [STICK_W-1:0] stick1;
        logic [STICK_W-1:0] stick2;
        logic [STICK_W-1:0] stick3;
        logic [3:0]         switch_pos;
        logic [MOUSE_W-1:0] mouse_motion;
        logic [1:0]         mouse_buttons;
        logic [KEY_W-1:0]   key_mask;
        logic [KEY_W-1:0]   key_changes;
        logic [1:0]         button_changes;
        logic [3:0]         switch_prev;
    } rcfd_out_t;

    typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] rcfd_bytes_t;

    // Decoded frame fields and the combined range check
    typedef struct packed {
        logic [NUM_STICKS-1:0][STICK_W-1:0] sticks;
        logic [3:0]                         switch_pos;
        logic [MOUSE_W-1:0]                 mouse_motion;
        logic [1:0]                         mouse_buttons;
        logic [KEY_W-1:0]                   key_mask;
        logic                               in_range;
    } rcfd_frame_t;

endpackage

/* rtl/rcfd_unpack.sv */
// Frame unpacker: splits the first sixteen frame bytes into fields and checks them.
// Pure combinational; uses types from rcfd_pkg.
module rcfd_unpack (
    input  rcfd_pkg::rcfd_bytes_t                frame,
    input  logic [rcfd_pkg::STICK_W-1:0]         stick_min,
    input  logic [rcfd_pkg::STICK_W-1:0]         stick_max,
    output rcfd_pkg::rcfd_frame_t                fields
);

    logic [rcfd_pkg::NUM_STICKS-1:0][rcfd_pkg::STICK_W-1:0] sticks;
    logic [rcfd_pkg::NUM_STICKS-1:0]                        stick_ok;
    logic [1:0] sw_one;
    logic [1:0] sw_two;
    logic       buttons_ok;

    // Sticks are packed LSB first across bytes 0..5
    assign sticks[0] = {frame[1][2:0], frame[0]};
    assign sticks[1] = {frame[2][5:0], frame[1][7:3]};
    assign sticks[2] = {frame[4][0], frame[3], frame[2][7:6]};
    assign sticks[3] = {frame[5][3:0], frame[4][7:1]};

    assign sw_one = frame[5][7:6];
    assign sw_two = frame[5][5:4];

    // Button bytes must be 0 or 1
    assign buttons_ok = (frame[12][7:1] == 7'd0) && (frame[13][7:1] == 7'd0);

    // Each stick strictly inside the limits
    always_comb begin
        for (int k = 0; k < rcfd_pkg::NUM_STICKS; k++) begin
            stick_ok[k] = (sticks[k] > stick_min) && (sticks[k] < stick_max);
        end
    end

    assign fields.sticks        = sticks;
    assign fields.switch_pos    = {sw_one, sw_two};
    assign fields.mouse_motion  = {frame[7], frame[6], frame[9], frame[8],
                                   frame[11], frame[10]};
    assign fields.mouse_buttons = {frame[12][0], frame[13][0]};
    assign fields.key_mask      = {frame[15], frame[14]};
    assign fields.in_range      = (sw_one != 2'd0) && (sw_two != 2'd0) && buttons_ok
                                  && (&stick_ok);

endmodule

/* rtl/rc_frame_decoder_unit.sv */
// Top level of the remote-control frame decoder: byte collection, frame state,
// calibration and change history. Depends on rcfd_pkg and rcfd_unpack.
//
//   channel   signals                              direction  word
//   s_        s_valid s_ready s_data (rcfd_in_t)   in         one received byte
//   m_        m_valid m_ready m_data (rcfd_out_t)  out        one frame result
//   cfg_      cfg_valid cfg_ready cfg_index cfg_data in       register write
//
// One byte per cycle sustained while no burst-end byte waits on a full result register.
// A byte is held in the input register, then the frame logic updates state and, on a
// burst end, loads the result register.
// Synchronous active-low reset restores register defaults and frame state.
// Only burst-end bytes wait on a full result register; other bytes never stall.
// cfg_ready is always high.
module rc_frame_decoder_unit #(
    parameter int FRAME_BYTES = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rcfd_pkg::rcfd_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rcfd_pkg::rcfd_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [rcfd_pkg::CNT_W-1:0] LAST_IDX = rcfd_pkg::CNT_W'(FRAME_BYTES - 1);
    localparam int SW = rcfd_pkg::STICK_W;
    localparam int NS = rcfd_pkg::NUM_STICKS;

    // Configuration registers
    logic [SW-1:0]                      stick_min_reg;
    logic [SW-1:0]                      stick_max_reg;
    logic [SW-1:0]                      stick_center_reg;
    logic [rcfd_pkg::LIMIT_W-1:0]       offset_limit_reg;
    logic [rcfd_pkg::THRESH_W-1:0]      history_after_reg;
    logic [rcfd_pkg::THRESH_W-1:0]      calibrate_after_reg;

    // Input register
    logic                               in_valid_reg;
    rcfd_pkg::rcfd_in_t                 in_data_reg;

    // Frame state
    rcfd_pkg::rcfd_bytes_t              frame_bytes_reg;
    logic [rcfd_pkg::CNT_W-1:0]         byte_count_reg;
    logic [rcfd_pkg::CNT_W-1:0]         byte_count_next;
    logic [NS-1:0][SW-1:0]              stick_store_reg;
    logic [NS-1:0][SW-1:0]              stick_store_next;
    logic [NS-1:0][rcfd_pkg::OFFSET_W-1:0] stick_offsets_reg;
    logic [NS-1:0][rcfd_pkg::OFFSET_W-1:0] stick_offsets_next;
    logic [NS-1:0][rcfd_pkg::OFFSET_W-1:0] cal_offset;
    logic                               calibrated_reg;
    logic                               calibrated_next;
    logic [rcfd_pkg::THRESH_W-1:0]      accepted_count_reg;
    logic [rcfd_pkg::THRESH_W-1:0]      accepted_count_next;
    logic                               history_on_reg;
    logic                               history_on_next;
    logic [3:0]                         switch_store_reg;
    logic [3:0]                         switch_store_next;
    logic [rcfd_pkg::MOUSE_W-1:0]       mouse_store_reg;
    logic [rcfd_pkg::MOUSE_W-1:0]       mouse_store_next;
    logic [1:0]                         button_store_reg;
    logic [1:0]                         button_store_next;
    logic [rcfd_pkg::KEY_W-1:0]         key_store_reg;
    logic [rcfd_pkg::KEY_W-1:0]         key_store_next;

    // Result register
    logic                               m_valid_reg;
    rcfd_pkg::rcfd_out_t                m_data_reg;
    rcfd_pkg::rcfd_out_t                result;

    logic                               advance;
    logic                               frame_done;
    logic                               full_len;
    logic [1:0]                         status;
    logic [rcfd_pkg::KEY_W-1:0]         key_changes;
    logic [1:0]                         button_changes;
    rcfd_pkg::rcfd_bytes_t              frame_view;
    rcfd_pkg::rcfd_frame_t              fields;

    // Handshake: a byte moves on unless it ends a burst and the result is still held
    assign advance    = in_valid_reg
                        && (!in_data_reg.burst_end || !m_valid_reg || m_ready);
    assign frame_done = advance && in_data_reg.burst_end;
    assign full_len   = (byte_count_reg == LAST_IDX);
    assign s_ready    = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_min_reg       <= rcfd_pkg::RST_STICK_MIN;
            stick_max_reg       <= rcfd_pkg::RST_STICK_MAX;
            stick_center_reg    <= rcfd_pkg::RST_STICK_CENTER;
            offset_limit_reg    <= rcfd_pkg::RST_OFFSET_LIMIT;
            history_after_reg   <= rcfd_pkg::RST_HISTORY_AFTER;
            calibrate_after_reg <= rcfd_pkg::RST_CALIBRATE_AFTER;
        end else if (cfg_valid) begin
            case (cfg_index)
                rcfd_pkg::CFG_STICK_MIN:       stick_min_reg    <= cfg_data;
                rcfd_pkg::CFG_STICK_MAX:       stick_max_reg    <= cfg_data;
                rcfd_pkg::CFG_STICK_CENTER:    stick_center_reg <= cfg_data;
                rcfd_pkg::CFG_OFFSET_LIMIT:
                    offset_limit_reg <= cfg_data[rcfd_pkg::LIMIT_W-1:0];
                rcfd_pkg::CFG_HISTORY_AFTER:
                    history_after_reg <= cfg_data[rcfd_pkg::THRESH_W-1:0];
                rcfd_pkg::CFG_CALIBRATE_AFTER:
                    calibrate_after_reg <= cfg_data[rcfd_pkg::THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload and byte store
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && (byte_count_reg < rcfd_pkg::CNT_W'(rcfd_pkg::STORE_DEPTH))) begin
            frame_bytes_reg[byte_count_reg[rcfd_pkg::STORE_IDX_W-1:0]] <= in_data_reg.rx_byte;
        end
    end

    // Forward the byte being written so a frame can end on the last stored byte
    always_comb begin
        for (int k = 0; k < rcfd_pkg::STORE_DEPTH; k++) begin
            frame_view[k] = (byte_count_reg == rcfd_pkg::CNT_W'(k))
                            ? in_data_reg.rx_byte : frame_bytes_reg[k];
        end
    end

    rcfd_unpack u_unpack (
        .frame     (frame_view),
        .stick_min (stick_min_reg),
        .stick_max (stick_max_reg),
        .fields    (fields)
    );

    // Calibration offsets: raw minus center, zeroed beyond the limit
    always_comb begin
        logic signed [rcfd_pkg::DIFF_W-1:0] diff;
        logic signed [rcfd_pkg::DIFF_W-1:0] lim;
        lim = $signed({{(rcfd_pkg::DIFF_W - rcfd_pkg::LIMIT_W){1'b0}}, offset_limit_reg});
        for (int k = 0; k < NS; k++) begin
            diff = $signed({1'b0, fields.sticks[k]}) - $signed({1'b0, stick_center_reg});
            if (diff > lim || diff < -lim) begin
                cal_offset[k] = '0;
            end else begin
                cal_offset[k] = diff[rcfd_pkg::OFFSET_W-1:0];
            end
        end
    end

    // Byte count: clear on burst end, saturate otherwise
    always_comb begin
        byte_count_next = byte_count_reg;
        if (advance) begin
            if (in_data_reg.burst_end) begin
                byte_count_next = '0;
            end else if (byte_count_reg != rcfd_pkg::CNT_MAX) begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    // Frame update on burst end
    always_comb begin
        stick_store_next    = stick_store_reg;
        stick_offsets_next  = stick_offsets_reg;
        calibrated_next     = calibrated_reg;
        accepted_count_next = accepted_count_reg;
        history_on_next     = history_on_reg;
        switch_store_next   = switch_store_reg;
        mouse_store_next    = mouse_store_reg;
        button_store_next   = button_store_reg;
        key_store_next      = key_store_reg;
        key_changes         = '0;
        button_changes      = '0;
        status              = rcfd_pkg::STATUS_BAD_LENGTH;
        if (frame_done && full_len) begin
            status = fields.in_range ? rcfd_pkg::STATUS_OK : rcfd_pkg::STATUS_BAD_RANGE;
            if (fields.in_range) begin
                if (calibrated_reg) begin
                    for (int k = 0; k < NS; k++) begin
                        stick_store_next[k] = fields.sticks[k]
                            - {{(SW - rcfd_pkg::OFFSET_W){stick_offsets_reg[k][rcfd_pkg::OFFSET_W-1]}},
                               stick_offsets_reg[k]};
                    end
                end else if (accepted_count_reg >= calibrate_after_reg) begin
                    stick_offsets_next = cal_offset;
                    calibrated_next    = 1'b1;
                end
                switch_store_next = fields.switch_pos;
                mouse_store_next  = fields.mouse_motion;
                button_store_next = fields.mouse_buttons;
                key_store_next    = fields.key_mask;
                if (accepted_count_reg != rcfd_pkg::ACC_MAX) begin
                    accepted_count_next = accepted_count_reg + 1'b1;
                end
            end
            if (history_on_reg) begin
                key_changes    = key_store_reg ^ key_store_next;
                button_changes = button_store_reg ^ button_store_next;
            end else if (accepted_count_next >= history_after_reg) begin
                history_on_next = 1'b1;
            end
        end
    end

    // Assemble the result word from the updated stores
    always_comb begin
        result.status         = status;
        result.stick0         = stick_store_next[0];
        result.stick1         = stick_store_next[1];
        result.stick2         = stick_store_next[2];
        result.stick3         = stick_store_next[3];
        result.switch_pos     = switch_store_next;
        result.mouse_motion   = mouse_store_next;
        result.mouse_buttons  = button_store_next;
        result.key_mask       = key_store_next;
        result.key_changes    = key_changes;
        result.button_changes = button_changes;
        result.switch_prev    = switch_store_reg;
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            for (int k = 0; k < NS; k++) begin
                stick_store_reg[k]   <= rcfd_pkg::RST_STICK_CENTER;
                stick_offsets_reg[k] <= '0;
            end
            calibrated_reg     <= 1'b0;
            accepted_count_reg <= '0;
            history_on_reg     <= 1'b0;
            switch_store_reg   <= rcfd_pkg::RST_SWITCHES;
            mouse_store_reg    <= '0;
            button_store_reg   <= '0;
            key_store_reg      <= '0;
        end else begin
            byte_count_reg     <= byte_count_next;
            stick_store_reg    <= stick_store_next;
            stick_offsets_reg  <= stick_offsets_next;
            calibrated_reg     <= calibrated_next;
            accepted_count_reg <= accepted_count_next;
            history_on_reg     <= history_on_next;
            switch_store_reg   <= switch_store_next;
            mouse_store_reg    <= mouse_store_next;
            button_store_reg   <= button_store_next;
            key_store_reg      <= key_store_next;
        end
    end

    // Result register: load on burst end, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (frame_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            m_data_reg <= result;
        end
    end

    // Checks
    a_result_from_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(frame_done))
        else $error("result appeared without a burst end word");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (byte_count_reg == '0))
        else $error("byte count not cleared after burst end");

    a_calibrated_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        calibrated_reg |=> calibrated_reg)
        else $error("calibration flag dropped");

    a_accepted_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (accepted_count_reg >= $past(accepted_count_reg)))
        else $error("accepted count went down");

    a_changes_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ((m_data_reg.key_changes != '0) || (m_data_reg.button_changes != '0)))
        |-> (m_data_reg.status == rcfd_pkg::STATUS_OK))
        else $error("changes reported on a rejected frame");

endmodule
